@@ rtl/variable_partition_allocator_defines.svh @@
// assertion macros used by the allocator controller
`ifndef VARIABLE_PARTITION_ALLOCATOR_DEFINES_SVH
`define VARIABLE_PARTITION_ALLOCATOR_DEFINES_SVH

`ifndef SYNTH
`define VPA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define VPA_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define VPA_ASSERT(label, prop, msg)
`define VPA_ASSERT_NEVER(label, expr, msg)
`endif

`endif

@@ rtl/vpa_pkg.sv @@
package vpa_pkg;

  localparam int MAX_PARTS = 16;
  localparam int ADDR_BITS = 16;
  localparam int IDX_W     = $clog2(MAX_PARTS);
  localparam int SZ_W      = ADDR_BITS + 1;
  localparam int TOTAL_W   = 17;
  localparam int REQ_W     = 17;
  localparam int OWNER_W   = 8;
  localparam int BASE_W    = 16;
  localparam int CLAMP_W   = (SZ_W > TOTAL_W) ? SZ_W : TOTAL_W;

  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef logic [SZ_W-1:0]      size_t;
  typedef logic [OWNER_W-1:0]   owner_t;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [1:0] POL_FIRST  = 2'd0;
  localparam logic [1:0] POL_BEST   = 2'd1;
  localparam logic [1:0] POL_WORST  = 2'd2;
  localparam logic [1:0] POL_UNUSED = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_HELD     = 3'd1;
  localparam logic [2:0] ST_NOSPACE  = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  localparam logic REG_FIT_POLICY = 1'b0;
  localparam logic REG_TOTAL_SIZE = 1'b1;

  localparam logic [TOTAL_W-1:0] TOTAL_RESET = TOTAL_W'(65536);

  typedef struct packed {
    logic                 func;
    logic [OWNER_W-1:0]   owner_id;
    logic [REQ_W-1:0]     request_size;
  } req_item_t;

  typedef struct packed {
    logic              ok;
    logic [BASE_W-1:0] base_address;
    logic [2:0]        status;
  } rsp_item_t;

  typedef enum logic {PH_MAIN, PH_MERGE} phase_t;

  typedef struct packed {
    logic   valid;
    addr_t  start;
    size_t  size;
    logic   used;
    owner_t owner;
  } ent_t;

  typedef struct packed {
    logic en;
    idx_t idx;
    ent_t ent;
  } wr_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic           restart;
    size_t          rsize;
    logic [1:0]     policy;
    owner_t         owner;
    size_t          req;
    idx_t           cur_idx;
    addr_t          cur_start;
    size_t          cur_size;
    wr_t [2:0]      wr;
  } cmd_t;

  // scan record handed from cell to cell
  typedef struct packed {
    logic   active;
    phase_t phase;
    logic   own_hit;
    idx_t   own_idx;
    addr_t  own_start;
    size_t  own_size;
    logic   pick_hit;
    idx_t   pick_idx;
    addr_t  pick_start;
    size_t  pick_size;
    logic   slot_hit;
    idx_t   slot_idx;
    logic   prev_hit;
    idx_t   prev_idx;
    size_t  prev_size;
    logic   next_hit;
    idx_t   next_idx;
    size_t  next_size;
  } carry_t;

  function automatic size_t clamp_total(logic [TOTAL_W-1:0] val);
    logic [CLAMP_W-1:0] cap;
    logic [CLAMP_W-1:0] v;
    cap = CLAMP_W'(1) << ADDR_BITS;
    v   = CLAMP_W'(val);
    return (v > cap) ? SZ_W'(cap) : SZ_W'(v);
  endfunction

  localparam size_t RESET_SIZE = clamp_total(TOTAL_RESET);

endpackage

@@ rtl/vpa_cell.sv @@
module vpa_cell
  import vpa_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  idx_t   idx,
  input  cmd_t   cmd,
  input  carry_t carry_in,
  output carry_t carry_out
);

  ent_t   e;
  carry_t nxt;
  logic   better;
  logic   fits;

  always_comb begin
    nxt    = carry_in;
    better = 1'b0;
    fits   = (e.size >= cmd.req);
    if (carry_in.active) begin
      if (carry_in.phase == PH_MAIN) begin
        if (!carry_in.own_hit && e.valid && e.used && e.owner == cmd.owner) begin
          nxt.own_hit   = 1'b1;
          nxt.own_idx   = idx;
          nxt.own_start = e.start;
          nxt.own_size  = e.size;
        end
        if (!carry_in.slot_hit && !e.valid) begin
          nxt.slot_hit = 1'b1;
          nxt.slot_idx = idx;
        end
        if (e.valid && !e.used) begin
          case (cmd.policy)
            POL_FIRST: better = fits && (!carry_in.pick_hit ||
                                         e.start < carry_in.pick_start);
            POL_BEST:  better = fits && (!carry_in.pick_hit ||
                                         e.size < carry_in.pick_size ||
                                         (e.size == carry_in.pick_size &&
                                          e.start < carry_in.pick_start));
            POL_WORST: better = !carry_in.pick_hit || e.size > carry_in.pick_size ||
                                (e.size == carry_in.pick_size &&
                                 e.start < carry_in.pick_start);
            default:   better = 1'b0;
          endcase
        end
        if (better) begin
          nxt.pick_hit   = 1'b1;
          nxt.pick_idx   = idx;
          nxt.pick_start = e.start;
          nxt.pick_size  = e.size;
        end
      end else if (idx != cmd.cur_idx && e.valid && !e.used) begin
        // neighbours that touch the released partition in address
        if (!carry_in.prev_hit && size_t'(e.start) + e.size == size_t'(cmd.cur_start)) begin
          nxt.prev_hit  = 1'b1;
          nxt.prev_idx  = idx;
          nxt.prev_size = e.size;
        end else if (!carry_in.next_hit &&
                     size_t'(e.start) == size_t'(cmd.cur_start) + cmd.cur_size) begin
          nxt.next_hit  = 1'b1;
          nxt.next_idx  = idx;
          nxt.next_size = e.size;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e         <= '0;
      carry_out <= '0;
      if (idx == '0) begin
        e.valid <= 1'b1;
        e.size  <= RESET_SIZE;
      end
    end else begin
      carry_out <= nxt;
      if (cmd.restart) begin
        e <= '0;
        if (idx == '0) begin
          e.valid <= 1'b1;
          e.size  <= cmd.rsize;
        end
      end else begin
        for (int w = 0; w < 3; w++) begin
          if (cmd.wr[w].en && cmd.wr[w].idx == idx) begin
            e <= cmd.wr[w].ent;
          end
        end
      end
    end
  end

endmodule

@@ rtl/vpa_ctrl.sv @@
`include "variable_partition_allocator_defines.svh"

module vpa_ctrl
  import vpa_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  req_item_t  req,
  output logic       rsp_valid,
  input  logic       rsp_ready,
  output rsp_item_t  rsp,
  input  logic [1:0] policy,
  input  logic       cfg_restart,
  input  size_t      cfg_rsize,
  input  carry_t     tail,
  output carry_t     head,
  output cmd_t       cmd
);

  typedef enum logic [1:0] {IDLE, SCAN1, SCAN2, DONE} state_t;

  state_t     state;
  logic       cur_func;
  logic       res_ok;
  addr_t      res_base;
  logic [2:0] res_status;
  logic [2:0] alloc_status;
  logic       split;
  idx_t       tgt_idx;
  addr_t      tgt_start;
  size_t      tgt_size;

  always_comb begin
    split = tail.pick_size > cmd.req;
    if (tail.own_hit) begin
      alloc_status = ST_HELD;
    end else if (cmd.req == '0 || cmd.policy == POL_UNUSED) begin
      alloc_status = ST_NOSPACE;
    end else if (!tail.pick_hit || tail.pick_size < cmd.req) begin
      alloc_status = ST_NOSPACE;
    end else if (split && !tail.slot_hit) begin
      alloc_status = ST_FULL;
    end else begin
      alloc_status = ST_OK;
    end
    // merged partition lands in the lower neighbour when there is one
    tgt_idx   = tail.prev_hit ? tail.prev_idx : cmd.cur_idx;
    tgt_start = tail.prev_hit ? addr_t'(size_t'(cmd.cur_start) - tail.prev_size)
                              : cmd.cur_start;
    tgt_size  = (tail.prev_hit ? tail.prev_size : '0) + cmd.cur_size +
                (tail.next_hit ? tail.next_size : '0);
  end

  assign req_ready = (state == IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      head      <= '0;
      cmd       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      head.active <= 1'b0;
      cmd.wr      <= '0;
      cmd.restart <= cfg_restart;
      cmd.rsize   <= cfg_rsize;
      cmd.policy  <= policy;
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (req_valid) begin
            cur_func   <= req.func;
            cmd.owner  <= req.owner_id;
            cmd.req    <= size_t'(req.request_size);
            head       <= '0;
            head.active <= 1'b1;
            head.phase <= PH_MAIN;
            state      <= SCAN1;
          end
        end
        SCAN1: begin
          if (tail.active) begin
            if (cur_func == FUNC_FREE) begin
              if (tail.own_hit) begin
                cmd.cur_idx   <= tail.own_idx;
                cmd.cur_start <= tail.own_start;
                cmd.cur_size  <= tail.own_size;
                head          <= '0;
                head.active   <= 1'b1;
                head.phase    <= PH_MERGE;
                state         <= SCAN2;
              end else begin
                res_ok     <= 1'b0;
                res_base   <= '0;
                res_status <= ST_NOTFOUND;
                state      <= DONE;
              end
            end else begin
              res_ok     <= (alloc_status == ST_OK);
              res_base   <= (alloc_status == ST_OK) ? tail.pick_start : '0;
              res_status <= alloc_status;
              if (alloc_status == ST_OK) begin
                cmd.wr[0].en        <= 1'b1;
                cmd.wr[0].idx       <= tail.pick_idx;
                cmd.wr[0].ent.valid <= 1'b1;
                cmd.wr[0].ent.start <= tail.pick_start;
                cmd.wr[0].ent.size  <= split ? cmd.req : tail.pick_size;
                cmd.wr[0].ent.used  <= 1'b1;
                cmd.wr[0].ent.owner <= cmd.owner;
                if (split) begin
                  cmd.wr[1].en        <= 1'b1;
                  cmd.wr[1].idx       <= tail.slot_idx;
                  cmd.wr[1].ent.valid <= 1'b1;
                  cmd.wr[1].ent.start <= addr_t'(size_t'(tail.pick_start) + cmd.req);
                  cmd.wr[1].ent.size  <= tail.pick_size - cmd.req;
                  cmd.wr[1].ent.used  <= 1'b0;
                  cmd.wr[1].ent.owner <= '0;
                end
              end
              state <= DONE;
            end
          end
        end
        SCAN2: begin
          if (tail.active) begin
            cmd.wr[0].en        <= 1'b1;
            cmd.wr[0].idx       <= tgt_idx;
            cmd.wr[0].ent.valid <= 1'b1;
            cmd.wr[0].ent.start <= tgt_start;
            cmd.wr[0].ent.size  <= tgt_size;
            cmd.wr[0].ent.used  <= 1'b0;
            cmd.wr[0].ent.owner <= '0;
            cmd.wr[1].en        <= tail.prev_hit;
            cmd.wr[1].idx       <= cmd.cur_idx;
            cmd.wr[1].ent       <= '0;
            cmd.wr[2].en        <= tail.next_hit;
            cmd.wr[2].idx       <= tail.next_idx;
            cmd.wr[2].ent       <= '0;
            res_ok     <= 1'b1;
            res_base   <= '0;
            res_status <= ST_OK;
            state      <= DONE;
          end
        end
        DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid        <= 1'b1;
            rsp.ok           <= res_ok;
            rsp.base_address <= BASE_W'(res_base);
            rsp.status       <= res_status;
            state            <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  `VPA_ASSERT(a_start_scan, (req_valid && req_ready) |=> head.active, "accepted transaction did not start a scan")
  `VPA_ASSERT(a_tail_scanning, tail.active |-> (state == SCAN1 || state == SCAN2), "scan record arrived outside a scan")
  `VPA_ASSERT(a_wr_order, cmd.wr[1].en |-> cmd.wr[0].en, "secondary table write without primary")
  `VPA_ASSERT_NEVER(a_wr_outside_done, cmd.wr[0].en && state != DONE, "table write outside completion")

endmodule

@@ rtl/variable_partition_allocator.sv @@
// Variable-size partition allocator. A row of MAX_PARTS cells each holds one table entry
// (start, size, allocated mark, owner); a scan record walks down the row one cell per
// cycle, collecting the owner match, the fit candidate and the first free slot. An
// allocate, or a free whose owner holds nothing, has its result registered once the scan
// record leaves the last cell; a free that finds its owner walks the row a second time
// for the address neighbours before its result is registered. One transaction is in
// flight at a time; a finished result waits in the output register while the next
// transaction is taken. Registers: fit policy at 0x0, total size at 0x4 (writing it
// restarts the table as one free partition). Write them only while no transaction is
// outstanding.
module variable_partition_allocator
  import vpa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  req_item_t   req,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output rsp_item_t   rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [1:0]         fit_policy;
  logic [TOTAL_W-1:0] total_size;
  logic               cfg_wr;
  logic               restart;
  carry_t             chain [MAX_PARTS+1];
  cmd_t               cmd;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_policy <= POL_FIRST;
      total_size <= TOTAL_RESET;
      restart    <= 1'b0;
    end else begin
      restart <= 1'b0;
      if (cfg_wr) begin
        case (paddr[2])
          REG_FIT_POLICY: fit_policy <= pwdata[1:0];
          REG_TOTAL_SIZE: begin
            total_size <= pwdata[TOTAL_W-1:0];
            restart    <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    case (paddr[2])
      REG_FIT_POLICY: prdata = 32'(fit_policy);
      REG_TOTAL_SIZE: prdata = 32'(total_size);
      default:        prdata = '0;
    endcase
  end

  vpa_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp),
    .policy     (fit_policy),
    .cfg_restart(restart),
    .cfg_rsize  (clamp_total(total_size)),
    .tail       (chain[MAX_PARTS]),
    .head       (chain[0]),
    .cmd        (cmd)
  );

  for (genvar g = 0; g < MAX_PARTS; g++) begin : g_cell
    vpa_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .idx      (IDX_W'(g)),
      .cmd      (cmd),
      .carry_in (chain[g]),
      .carry_out(chain[g+1])
    );
  end

endmodule
